FILE: rtl/core/keaq_pkg.sv
// Shared types and constants for the keyboard event auto-repeat queue.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package keaq_pkg;

	localparam int KEY_W       = 7;
	localparam int TIME_W      = 48;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int SCAN_CNT_W  = KEY_W + 1;
	localparam int EVENT_W     = KEY_W + 1;

	localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h1D;
	localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
	localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
	localparam logic [KEY_W-1:0] KEY_UP     = 7'h48;
	localparam logic [KEY_W-1:0] KEY_DOWN   = 7'h50;

	localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd400;
	localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd40;

	typedef enum logic [1:0] {
		ACT_BYTE = 2'd0,
		ACT_TICK = 2'd1,
		ACT_POP  = 2'd2,
		ACT_NOP  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INITIAL_DELAY   = 1'b0,
		CFG_REPEAT_INTERVAL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              kd_we;
		logic [KEY_W-1:0]  kd_waddr;
		logic              kd_wval;
		logic [KEY_W-1:0]  kd_raddr;
		logic              due_we;
		logic [KEY_W-1:0]  due_waddr;
		logic [TIME_W-1:0] due_wdata;
		logic              due_re;
		logic [KEY_W-1:0]  due_raddr;
	} key_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/keaq_time_alu.sv
// Shared time unit: one 48-bit add of a 16-bit offset and one unsigned compare.
// Depends on keaq_pkg.
`default_nettype none

module keaq_time_alu
	import keaq_pkg::*;
(
	input  wire logic [TIME_W-1:0] base,
	input  wire logic [CFG_W-1:0]  addend,
	input  wire logic [TIME_W-1:0] now,
	output logic      [TIME_W-1:0] sum,
	output logic                   reached
);

	assign sum     = base + {{(TIME_W-CFG_W){1'b0}}, addend};
	assign reached = (now >= base);

endmodule

`default_nettype wire

FILE: rtl/core/keaq_key_store.sv
// Per-key state: held flags in flip-flops and repeat times in a 128 x 48 memory.
// Depends on keaq_pkg.
`default_nettype none

module keaq_key_store
	import keaq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire key_req_t          req,
	output logic                   kd_rdata,
	output logic      [TIME_W-1:0] due_rdata
);

	localparam int KEY_COUNT = 2 ** KEY_W;

	logic [KEY_COUNT-1:0] kd_q;
	logic [TIME_W-1:0]    due_mem [KEY_COUNT];
	logic [TIME_W-1:0]    due_rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kd_q <= '0;
		end else if (req.kd_we) begin
			kd_q[req.kd_waddr] <= req.kd_wval;
		end
	end

	always_ff @(posedge clk) begin
		if (req.due_we) begin
			due_mem[req.due_waddr] <= req.due_wdata;
		end
		if (req.due_re) begin
			due_rdata_q <= due_mem[req.due_raddr];
		end
	end

	assign kd_rdata  = kd_q[req.kd_raddr];
	assign due_rdata = due_rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/keaq_fifo.sv
// Event queue that keeps one slot empty, with a registered read port.
// Depends on keaq_pkg.
`default_nettype none

module keaq_fifo
	import keaq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [EVENT_W-1:0] push_data,
	input  wire logic               pop,
	output logic                    full,
	output logic                    empty,
	output logic      [EVENT_W-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [PW-1:0]      wr_next;
	logic [PW-1:0]      rd_next;
	logic [EVENT_W-1:0] mem [DEPTH];
	logic [EVENT_W-1:0] rd_data_q;

	assign wr_next = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign full    = (wr_next == rd_ptr_q);
	assign empty   = (wr_ptr_q == rd_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_next;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (pop && !empty) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/keyboard_event_autorepeat_queue.sv
// Keyboard event queue with typematic auto-repeat, top level and sequencer.
// A scan code byte, an unused action or a pop of an empty queue goes through the decode and done
// states; a pop that finds an event also through the pop state. A tick runs the scan state, which
// reads one repeat time per cycle and writes back the previous key's time via the time unit. One
// beat is in work at a time; the next is accepted in the cycle after its result is loaded.
// Reset clears held keys, modifier flags and queue pointers and loads register defaults.
`default_nettype none

module keyboard_event_autorepeat_queue
	import keaq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	input  wire logic [7:0]           scan_byte,
	input  wire logic [TIME_W-1:0]    now_ms,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      event_valid,
	output logic      [KEY_W-1:0]     event_key,
	output logic                      event_down,
	output logic                      scroll_up_pulse,
	output logic                      scroll_down_pulse,
	output logic                      ctrl_held,
	output logic                      shift_held,
	output logic                      event_dropped,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_POP    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                state_q;
	action_t               action_q;
	logic [7:0]            byte_q;
	logic [TIME_W-1:0]     now_q;
	logic [CFG_W-1:0]      delay_q;
	logic [CFG_W-1:0]      interval_q;
	logic                  ctrl_flag_q;
	logic                  shift_flag_q;
	logic [SCAN_CNT_W-1:0] scan_cnt_q;
	logic                  scan_vld_s1;
	logic [KEY_W-1:0]      scan_idx_s1;
	logic                  res_valid_q;
	logic [KEY_W-1:0]      res_key_q;
	logic                  res_down_q;
	logic                  res_sup_q;
	logic                  res_sdown_q;
	logic                  res_drop_q;
	logic                  out_valid_q;

	logic                  in_decode;
	logic                  in_scan;
	logic                  is_byte;
	logic [KEY_W-1:0]      byte_key;
	logic                  byte_down;
	logic                  new_ev;
	logic                  shift_next;
	logic                  is_sup;
	logic                  is_sdown;
	logic                  byte_push;
	logic                  scan_hit;
	logic                  out_load;

	key_req_t              key_req;
	logic                  kd_rdata;
	logic [TIME_W-1:0]     due_rdata;
	logic [TIME_W-1:0]     alu_base;
	logic [CFG_W-1:0]      alu_addend;
	logic [TIME_W-1:0]     alu_sum;
	logic                  alu_reached;

	logic                  fifo_push;
	logic [EVENT_W-1:0]    fifo_push_data;
	logic                  fifo_pop;
	logic                  fifo_full;
	logic                  fifo_empty;
	logic [EVENT_W-1:0]    fifo_rd_data;
	logic                  drop;

	assign in_decode = (state_q == S_DECODE);
	assign in_scan   = (state_q == S_SCAN);
	assign is_byte   = in_decode && (action_q == ACT_BYTE);
	assign byte_key  = byte_q[KEY_W-1:0];
	assign byte_down = !byte_q[7];
	assign new_ev    = !(byte_down && kd_rdata);
	assign shift_next = (byte_key == KEY_LSHIFT || byte_key == KEY_RSHIFT) ?
		byte_down : shift_flag_q;
	assign is_sup    = new_ev && byte_down && (byte_key == KEY_UP) && !shift_next;
	assign is_sdown  = new_ev && byte_down && (byte_key == KEY_DOWN);
	assign byte_push = new_ev && !is_sup && !is_sdown;
	assign scan_hit  = in_scan && scan_vld_s1 && kd_rdata && alu_reached;

	always_comb begin
		key_req.kd_we     = is_byte && new_ev;
		key_req.kd_waddr  = byte_key;
		key_req.kd_wval   = byte_down;
		key_req.kd_raddr  = in_decode ? byte_key : scan_idx_s1;
		key_req.due_we    = (is_byte && new_ev && byte_down) || scan_hit;
		key_req.due_waddr = in_decode ? byte_key : scan_idx_s1;
		key_req.due_wdata = alu_sum;
		key_req.due_re    = in_scan && !scan_cnt_q[SCAN_CNT_W-1];
		key_req.due_raddr = scan_cnt_q[KEY_W-1:0];
	end

	assign alu_base   = in_scan ? due_rdata : now_q;
	assign alu_addend = in_scan ? interval_q : delay_q;

	assign fifo_push      = (is_byte && byte_push) || scan_hit;
	assign fifo_push_data = in_decode ? {byte_down, byte_key} : {1'b1, scan_idx_s1};
	assign fifo_pop       = in_decode && (action_q == ACT_POP);
	assign drop           = fifo_push && fifo_full;

	keaq_time_alu u_alu (
		.base    (alu_base),
		.addend  (alu_addend),
		.now     (now_q),
		.sum     (alu_sum),
		.reached (alu_reached)
	);

	keaq_key_store u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (key_req),
		.kd_rdata  (kd_rdata),
		.due_rdata (due_rdata)
	);

	keaq_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (fifo_push_data),
		.pop       (fifo_pop),
		.full      (fifo_full),
		.empty     (fifo_empty),
		.rd_data   (fifo_rd_data)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			delay_q      <= DELAY_RESET;
			interval_q   <= INTERVAL_RESET;
			ctrl_flag_q  <= 1'b0;
			shift_flag_q <= 1'b0;
			scan_cnt_q   <= '0;
			scan_vld_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_INITIAL_DELAY:   delay_q <= cfg_wdata;
					CFG_REPEAT_INTERVAL: interval_q <= cfg_wdata;
					default: ;
				endcase
			end
			scan_vld_s1 <= key_req.due_re;
			if (key_req.due_re) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					scan_cnt_q <= '0;
					if (is_byte) begin
						if (byte_key == KEY_CTRL) begin
							ctrl_flag_q <= byte_down;
						end
						shift_flag_q <= shift_next;
					end
					if (action_q == ACT_TICK) begin
						state_q <= S_SCAN;
					end else if (action_q == ACT_POP && !fifo_empty) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (scan_cnt_q[SCAN_CNT_W-1] && !scan_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_POP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_cnt_q[KEY_W-1:0];
		if (state_q == S_IDLE && in_valid) begin
			action_q <= action_t'(action);
			byte_q   <= scan_byte;
			now_q    <= now_ms;
		end
		if (in_decode) begin
			res_valid_q <= 1'b0;
			res_key_q   <= '0;
			res_down_q  <= 1'b0;
			res_sup_q   <= is_byte && is_sup;
			res_sdown_q <= is_byte && is_sdown;
			res_drop_q  <= drop;
		end
		if (in_scan && drop) begin
			res_drop_q <= 1'b1;
		end
		if (state_q == S_POP) begin
			res_valid_q <= 1'b1;
			res_key_q   <= fifo_rd_data[KEY_W-1:0];
			res_down_q  <= fifo_rd_data[EVENT_W-1];
		end
		if (out_load) begin
			event_valid       <= res_valid_q;
			event_key         <= res_key_q;
			event_down        <= res_down_q;
			scroll_up_pulse   <= res_sup_q;
			scroll_down_pulse <= res_sdown_q;
			ctrl_held         <= ctrl_flag_q;
			shift_held        <= shift_flag_q;
			event_dropped     <= res_drop_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/keaq_checker.sv
// Port-level checks for the keyboard event auto-repeat queue, bound to the top level.
// Depends on keaq_pkg and keyboard_event_autorepeat_queue.
`default_nettype none

module keaq_checker
	import keaq_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             event_valid,
	input wire logic [KEY_W-1:0] event_key,
	input wire logic             event_down,
	input wire logic             scroll_up_pulse,
	input wire logic             scroll_down_pulse,
	input wire logic             event_dropped
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_valid) &&
		$stable(event_key) && $stable(event_down) && $stable(event_dropped))
		else $error("stalled result beat changed");

	// The block works on one beat at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a beat is in work");

	// Key and direction read as zero when no event was popped.
	a_empty_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_valid |-> (event_key == '0) && !event_down)
		else $error("event fields set without a popped event");

	// A scroll press queues nothing and pops nothing.
	a_scroll_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (scroll_up_pulse || scroll_down_pulse) |->
		!event_valid && !event_dropped && !(scroll_up_pulse && scroll_down_pulse))
		else $error("scroll pulse together with a queue event");

endmodule

bind keyboard_event_autorepeat_queue keaq_checker u_keaq_checker (.*);

`default_nettype wire
